[hdl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and codes for the round-robin thread scheduler
// Request codes, status codes, slot states and the slot table entry type.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // default number of thread slots
  localparam int THREADS_DEF = 16;

  // width of the sleep countdown
  localparam int SLEEP_W = 32;

  // request codes on the input word
  typedef enum logic [2:0] {
    REQ_ADD   = 3'd0,
    REQ_KILL  = 3'd1,
    REQ_SLEEP = 3'd2,
    REQ_TICK  = 3'd3,
    REQ_YIELD = 3'd4
  } req_t;

  // status codes on the result word
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOCUR = 2'd2;

  // slot states
  typedef enum logic [1:0] {
    SLOT_DEAD     = 2'd0,
    SLOT_ALIVE    = 2'd1,
    SLOT_SLEEPING = 2'd2
  } slot_state_t;

  // one slot table entry
  typedef struct packed {
    slot_state_t          state;
    logic [SLEEP_W-1:0]   sleep_left;
  } slot_entry_t;

endpackage

[hdl/round_robin_thread_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_unit: round-robin thread scheduler with sleep
// Slot table of dead / alive / sleeping threads plus the current thread,
// walked one slot per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one request word per item; in_tuser carries the
//   request code, in_tdata the sleep tick count. Output stream (out_*): one
//   result word per request. Config channel (cfg_*): preemptive bit, always
//   ready; write it only while the block is idle.
// Slot walks:
//   The slot table is one memory with a single read port, walked one slot per
//   cycle. Add walks up to THREADS slots. Kill, sleep, yield: one reschedule
//   walk of THREADS-1 slots. Tick walks all THREADS slots, plus a reschedule
//   walk when preemptive with a current thread. Requests that need no walk go
//   straight to the result. in_tready comes back with the result, so no new
//   word is taken while a request is in flight.
// Reset:
//   All slots dead, no current thread, preemptive cleared; no result pending.
// Stall:
//   The result sits in the output register until taken; the block takes the
//   next request meanwhile but holds its own result until the register frees.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_unit
  import rrts_pkg::*;
#(
  parameter int THREADS = THREADS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sleep_ticks
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] status, [5:2] current_thread,
                                  // [6] current_valid, [7] switched,
                                  // [11:8] granted_slot, [15:12] zero
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // preemptive
);

  localparam int IW = $clog2(THREADS);
  localparam int CW = $clog2(THREADS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(THREADS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_TICK,
    S_RESCH,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic          present_r, present_nxt;
  logic          preempt_r;
  logic [1:0]    status_r, status_nxt;
  logic [IW-1:0] new_slot_r, new_slot_nxt;
  logic [IW-1:0] old_idx_r, old_idx_nxt;
  logic          old_present_r, old_present_nxt;
  logic [IW-1:0] raddr_r, raddr_nxt;
  logic [CW-1:0] issued_r, issued_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic          pend_r, pend_nxt;
  logic          plast_r, plast_nxt;
  logic [IW-1:0] paddr_r, paddr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_data_r, out_data_nxt;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  slot_entry_t   rd_entry;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_entry_t   wr_entry;

  logic          in_fire;
  logic [3:0]    cur4;
  logic [3:0]    new4;
  logic          switched;
  logic [IW-1:0] cur_next_idx;
  logic [SLEEP_W-1:0] dec_left;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // low four bits of slot indices, zero-extended for small tables
  for (genvar b = 0; b < 4; b++) begin : g_idx4
    if (b < IW) begin : g_bit
      assign cur4[b] = cur_r[b];
      assign new4[b] = new_slot_r[b];
    end else begin : g_zero
      assign cur4[b] = 1'b0;
      assign new4[b] = 1'b0;
    end
  end

  // slot after the current one, wrapping
  assign cur_next_idx = (cur_r == LAST_IDX) ? '0 : cur_r + 1'b1;

  // countdown step for a sleeping slot
  assign dec_left = (rd_entry.sleep_left != '0) ? rd_entry.sleep_left - 1'b1 : '0;

  assign switched = (old_present_r != present_r) ||
                    (present_r && (old_idx_r != cur_r));

  rrts_slot_table #(
    .THREADS (THREADS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  // sequencer next state
  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    present_nxt     = present_r;
    status_nxt      = status_r;
    new_slot_nxt    = new_slot_r;
    old_idx_nxt     = old_idx_r;
    old_present_nxt = old_present_r;
    raddr_nxt       = raddr_r;
    issued_nxt      = issued_r;
    total_nxt       = total_r;
    pend_nxt        = 1'b0;
    plast_nxt       = 1'b0;
    paddr_nxt       = paddr_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    rd_en           = 1'b0;
    rd_addr         = raddr_r;
    wr_en           = 1'b0;
    wr_addr         = cur_r;
    wr_entry.state      = SLOT_DEAD;
    wr_entry.sleep_left = '0;

    // output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // scan issue: one read per cycle while walking the table
    if ((state_r == S_ADD || state_r == S_TICK || state_r == S_RESCH) &&
        (issued_r != total_r)) begin
      rd_en      = 1'b1;
      issued_nxt = issued_r + 1'b1;
      raddr_nxt  = (raddr_r == LAST_IDX) ? '0 : raddr_r + 1'b1;
      pend_nxt   = 1'b1;
      plast_nxt  = ((issued_r + 1'b1) == total_r);
      paddr_nxt  = raddr_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          status_nxt      = ST_OK;
          new_slot_nxt    = '0;
          old_idx_nxt     = cur_r;
          old_present_nxt = present_r;
          issued_nxt      = '0;
          state_nxt       = S_DONE;
          case (req_t'(in_tuser))
            REQ_ADD: begin
              raddr_nxt = '0;
              total_nxt = CW'(THREADS);
              state_nxt = S_ADD;
            end
            REQ_KILL: begin
              if (!present_r) begin
                status_nxt = ST_NOCUR;
              end else begin
                wr_en          = 1'b1;
                wr_entry.state = SLOT_DEAD;
                raddr_nxt      = cur_next_idx;
                total_nxt      = CW'(THREADS - 1);
                state_nxt      = S_RESCH;
              end
            end
            REQ_SLEEP: begin
              if (!present_r) begin
                status_nxt = ST_NOCUR;
              end else if (in_tdata != '0) begin
                wr_en               = 1'b1;
                wr_entry.state      = SLOT_SLEEPING;
                wr_entry.sleep_left = in_tdata;
                raddr_nxt           = cur_next_idx;
                total_nxt           = CW'(THREADS - 1);
                state_nxt           = S_RESCH;
              end
            end
            REQ_TICK: begin
              raddr_nxt = '0;
              total_nxt = CW'(THREADS);
              state_nxt = S_TICK;
            end
            REQ_YIELD: begin
              if (present_r) begin
                raddr_nxt = cur_next_idx;
                total_nxt = CW'(THREADS - 1);
                state_nxt = S_RESCH;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // lowest dead slot
      S_ADD: begin
        if (pend_r) begin
          if (rd_entry.state == SLOT_DEAD) begin
            wr_en          = 1'b1;
            wr_addr        = paddr_r;
            wr_entry.state = SLOT_ALIVE;
            new_slot_nxt   = paddr_r;
            if (!present_r) begin
              cur_nxt     = paddr_r;
              present_nxt = 1'b1;
            end
            pend_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else if (plast_r) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end
        end
      end

      // count sleepers down, wake at zero
      S_TICK: begin
        if (pend_r) begin
          if (rd_entry.state == SLOT_SLEEPING) begin
            wr_en               = 1'b1;
            wr_addr             = paddr_r;
            wr_entry.sleep_left = dec_left;
            wr_entry.state      = (dec_left == '0) ? SLOT_ALIVE : SLOT_SLEEPING;
          end
          if (plast_r) begin
            if (preempt_r && present_r) begin
              raddr_nxt  = cur_next_idx;
              issued_nxt = '0;
              total_nxt  = CW'(THREADS - 1);
              state_nxt  = S_RESCH;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end

      // next alive slot after the current one
      S_RESCH: begin
        if (pend_r) begin
          if (rd_entry.state == SLOT_ALIVE) begin
            cur_nxt   = paddr_r;
            pend_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else if (plast_r) begin
            state_nxt = S_DONE;
          end
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, new4, switched, present_r,
                           present_r ? cur4 : 4'b0000, status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      present_r   <= 1'b0;
      preempt_r   <= 1'b0;
      pend_r      <= 1'b0;
      plast_r     <= 1'b0;
      issued_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      present_r   <= present_nxt;
      pend_r      <= pend_nxt;
      plast_r     <= plast_nxt;
      issued_r    <= issued_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        preempt_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    new_slot_r    <= new_slot_nxt;
    old_idx_r     <= old_idx_nxt;
    old_present_r <= old_present_nxt;
    raddr_r       <= raddr_nxt;
    paddr_r       <= paddr_nxt;
    out_data_r    <= out_data_nxt;
  end

endmodule

[hdl/rrts_slot_table.sv]
// ----------------------------------------------------------------------------
// rrts_slot_table: per-slot state and sleep countdown storage
// One write port, one read port with registered data. A valid bit per entry
// makes every slot read as dead with a zero countdown after reset.
// ----------------------------------------------------------------------------
module rrts_slot_table
  import rrts_pkg::*;
#(
  parameter int THREADS = THREADS_DEF,
  localparam int IW = $clog2(THREADS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output slot_entry_t   rd_entry,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  slot_entry_t   wr_entry
);

  slot_entry_t        mem_r [THREADS];
  logic [THREADS-1:0] vld_r;
  slot_entry_t        rd_q_r;
  logic               rd_vld_r;

  // valid bits and the valid flag of the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // never-written entries read as dead
  always_comb begin
    if (rd_vld_r) begin
      rd_entry = rd_q_r;
    end else begin
      rd_entry.state      = SLOT_DEAD;
      rd_entry.sleep_left = '0;
    end
  end

endmodule

[hdl/rrts_checker.sv]
// ----------------------------------------------------------------------------
// rrts_checker: port-level checks for the thread scheduler
// Watches the top level's streams and is bound onto every instance.
// ----------------------------------------------------------------------------
module rrts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  // one request in flight: not ready right after taking a word
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

  // no current thread means a zero thread index
  a_cur_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[6] |-> out_tdata[5:2] == 4'd0)
    else $error("thread index without a current thread");

  // a granted slot only comes with ok status, and status is never three
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3) &&
                   ((out_tdata[11:8] == 4'd0) || (out_tdata[1:0] == 2'd0)))
    else $error("inconsistent status on result word");

endmodule

bind round_robin_thread_scheduler_unit rrts_checker u_rrts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
